@@ hdl/gect_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gect_pkg: shared types and codes
// Event opcodes, control kinds, axis directions and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gect_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_BUTTON = 2'd2;
   localparam logic [1:0] OP_AXIS   = 2'd3;

   localparam logic [1:0] KIND_BUTTON = 2'd0;

   localparam logic [1:0] DIR_CENTER = 2'd0;
   localparam logic [1:0] DIR_PLUS   = 2'd1;
   localparam logic [1:0] DIR_MINUS  = 2'd2;

   localparam logic [14:0] THRESHOLD_RESET = 15'h1fff;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic select;
      logic alloc;
      logic remove;
      logic update;
      logic emit_rel;
      logic emit_press;
      logic walk_step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       hit;
      logic       free_found;
      logic       idx_ok;
      logic       out_free;
      logic       walk_empty;
      logic       rel_valid;
      logic       press_valid;
   } stat_type;

endpackage
`default_nettype wire

@@ hdl/gect_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gect_req_if: controller event channel
// Valid/ready channel that carries one raw controller event per transfer.
// ----------------------------------------------------------------------------
interface gect_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [31:0] dev_handle;
   logic [7:0]         index;
   logic signed [15:0] value;

   modport source (output valid, op, dev_handle, index, value, input ready);
   modport sink   (input valid, op, dev_handle, index, value, output ready);
endinterface
`default_nettype wire

@@ hdl/gect_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gect_rsp_if: control change channel
// Valid/ready channel that carries one press or release change per transfer.
// ----------------------------------------------------------------------------
interface gect_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] slot;
   logic [1:0] control_kind;
   logic [4:0] control_index;
   logic       pressed;
   logic       last;

   modport source (output valid, slot, control_kind, control_index, pressed, last,
                   input ready);
   modport sink   (input valid, slot, control_kind, control_index, pressed, last,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/gect_csr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gect_csr_if: threshold register write channel
// Valid/ready channel that writes the axis threshold register.
// ----------------------------------------------------------------------------
interface gect_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hdl/gect_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gect_datapath: slot table, control state and result register
// Holds the device-to-slot table, per-slot button and axis state, the
// threshold register, the removal walk shifters and the output register.
// ----------------------------------------------------------------------------
module gect_datapath
   import gect_pkg::*;
#(
   parameter int MAX_SLOTS    = 8,
   parameter int BUTTON_COUNT = 32,
   parameter int AXIS_COUNT   = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         req_op,
   input  wire logic signed [31:0] req_dev_handle,
   input  wire logic [7:0]         req_index,
   input  wire logic signed [15:0] req_value,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   gect_rsp_if.source              rsp_if,
   gect_csr_if.sink                csr_if
);

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   logic [14:0]             thr_ff;
   logic [1:0]              op_ff;
   logic [31:0]             dev_ff;
   logic [7:0]              idx_ff;
   logic signed [15:0]      val_ff;

   logic [MAX_SLOTS-1:0]    in_use_ff;
   logic [31:0]             dev_tab_ff [MAX_SLOTS];
   logic [BUTTON_COUNT-1:0] btn_ff [MAX_SLOTS];
   logic [2*AXIS_COUNT-1:0] axis_ff [MAX_SLOTS];

   logic                    hit_ff;
   logic [SW-1:0]           hit_slot_ff;
   logic                    free_ff;
   logic [SW-1:0]           free_slot_ff;
   logic [SW-1:0]           cur_slot_ff;

   logic                    rel_valid_ff;
   logic [1:0]              rel_kind_ff;
   logic                    press_valid_ff;
   logic [1:0]              press_kind_ff;

   logic [BUTTON_COUNT-1:0] btn_walk_ff;
   logic [2*AXIS_COUNT-1:0] axis_walk_ff;
   logic [BW-1:0]           btn_cnt_ff;
   logic [AW-1:0]           axis_cnt_ff;

   logic                    rsp_valid_ff;
   logic [2:0]              rsp_slot_ff;
   logic [1:0]              rsp_kind_ff;
   logic [4:0]              rsp_index_ff;
   logic                    rsp_pressed_ff;
   logic                    rsp_last_ff;

   logic [MAX_SLOTS-1:0]    match;
   logic                    hit_in;
   logic [SW-1:0]           hit_slot_in;
   logic                    free_in;
   logic [SW-1:0]           free_slot_in;

   logic [BW-1:0]           bidx;
   logic [AW-1:0]           aidx;
   logic                    held;
   logic                    pr;
   logic [1:0]              prev;
   logic [1:0]              dir;
   logic signed [16:0]      val17;
   logic signed [16:0]      thr17;
   logic                    upd_rel_valid;
   logic [1:0]              upd_rel_kind;
   logic                    upd_press_valid;
   logic [1:0]              upd_press_kind;

   logic                    btn_phase;
   logic                    walk_emit;
   logic [1:0]              walk_kind;
   logic [4:0]              walk_index;
   logic                    walk_last;

   logic                    out_free;
   logic                    load;
   logic [1:0]              load_kind;
   logic [4:0]              load_index;
   logic                    load_pressed;
   logic                    load_last;

   // slot lookup: known device and lowest free slot
   always_comb begin
      hit_in       = 1'b0;
      hit_slot_in  = '0;
      free_in      = 1'b0;
      free_slot_in = '0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
         match[s] = in_use_ff[s] && (dev_tab_ff[s] == dev_ff);
      end
      for (int s = 0; s < MAX_SLOTS; s++) begin
         if (match[s] && !hit_in) begin
            hit_in      = 1'b1;
            hit_slot_in = SW'(s);
         end
         if (!in_use_ff[s] && !free_in) begin
            free_in      = 1'b1;
            free_slot_in = SW'(s);
         end
      end
   end

   // state update for one button or axis event
   always_comb begin
      bidx  = idx_ff[BW-1:0];
      aidx  = idx_ff[AW-1:0];
      held  = btn_ff[cur_slot_ff][bidx];
      pr    = (val_ff != 16'sd0);
      prev  = axis_ff[cur_slot_ff][2*aidx +: 2];
      val17 = 17'(val_ff);
      thr17 = $signed({2'b00, thr_ff});
      if (val17 > thr17) begin
         dir = DIR_PLUS;
      end else if (val17 < -thr17) begin
         dir = DIR_MINUS;
      end else begin
         dir = DIR_CENTER;
      end
      if (op_ff == OP_BUTTON) begin
         upd_rel_valid   = (pr != held) && !pr;
         upd_press_valid = (pr != held) && pr;
         upd_rel_kind    = KIND_BUTTON;
         upd_press_kind  = KIND_BUTTON;
      end else begin
         upd_rel_valid   = (dir != prev) && (prev != DIR_CENTER);
         upd_press_valid = (dir != prev) && (dir != DIR_CENTER);
         upd_rel_kind    = prev;
         upd_press_kind  = dir;
      end
   end

   // removal walk: buttons first, then axes
   always_comb begin
      btn_phase = (btn_walk_ff != '0);
      if (btn_phase) begin
         walk_emit  = btn_walk_ff[0];
         walk_kind  = KIND_BUTTON;
         walk_index = 5'(btn_cnt_ff);
         walk_last  = ((btn_walk_ff >> 1) == '0) && (axis_walk_ff == '0);
      end else begin
         walk_emit  = (axis_walk_ff[1:0] != DIR_CENTER);
         walk_kind  = axis_walk_ff[1:0];
         walk_index = 5'(axis_cnt_ff);
         walk_last  = ((axis_walk_ff >> 2) == '0);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      load         = 1'b0;
      load_kind    = KIND_BUTTON;
      load_index   = idx_ff[4:0];
      load_pressed = 1'b0;
      load_last    = 1'b0;
      priority if (cmd.emit_rel) begin
         load      = 1'b1;
         load_kind = rel_kind_ff;
         load_last = !press_valid_ff;
      end else if (cmd.emit_press) begin
         load         = 1'b1;
         load_kind    = press_kind_ff;
         load_pressed = 1'b1;
         load_last    = 1'b1;
      end else if (cmd.walk_step && walk_emit) begin
         load       = 1'b1;
         load_kind  = walk_kind;
         load_index = walk_index;
         load_last  = walk_last;
      end else begin
         load = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_SLOTS; s++) begin
            btn_ff[s]  <= '0;
            axis_ff[s] <= '0;
         end
      end else begin
         if (csr_if.valid) begin
            thr_ff <= csr_if.data;
         end
         if (cmd.alloc) begin
            in_use_ff[free_slot_ff] <= 1'b1;
            btn_ff[free_slot_ff]    <= '0;
            axis_ff[free_slot_ff]   <= '0;
         end
         if (cmd.remove) begin
            in_use_ff[hit_slot_ff] <= 1'b0;
         end
         if (cmd.update) begin
            if (op_ff == OP_BUTTON) begin
               btn_ff[cur_slot_ff][bidx] <= pr;
            end else begin
               axis_ff[cur_slot_ff][2*aidx +: 2] <= dir;
            end
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         dev_ff <= req_dev_handle;
         idx_ff <= req_index;
         val_ff <= req_value;
      end
      if (cmd.lookup) begin
         hit_ff       <= hit_in;
         hit_slot_ff  <= hit_slot_in;
         free_ff      <= free_in;
         free_slot_ff <= free_slot_in;
      end
      if (cmd.select) begin
         cur_slot_ff <= hit_ff ? hit_slot_ff : free_slot_ff;
      end
      if (cmd.alloc) begin
         dev_tab_ff[free_slot_ff] <= dev_ff;
      end
      if (cmd.update) begin
         rel_valid_ff   <= upd_rel_valid;
         rel_kind_ff    <= upd_rel_kind;
         press_valid_ff <= upd_press_valid;
         press_kind_ff  <= upd_press_kind;
      end
      if (cmd.remove) begin
         btn_walk_ff  <= btn_ff[hit_slot_ff];
         axis_walk_ff <= axis_ff[hit_slot_ff];
         btn_cnt_ff   <= '0;
         axis_cnt_ff  <= '0;
      end else if (cmd.walk_step) begin
         if (btn_phase) begin
            btn_walk_ff <= btn_walk_ff >> 1;
            btn_cnt_ff  <= btn_cnt_ff + 1'b1;
         end else begin
            axis_walk_ff <= axis_walk_ff >> 2;
            axis_cnt_ff  <= axis_cnt_ff + 1'b1;
         end
      end
      if (load) begin
         rsp_slot_ff    <= 3'(cur_slot_ff);
         rsp_kind_ff    <= load_kind;
         rsp_index_ff   <= load_index;
         rsp_pressed_ff <= load_pressed;
         rsp_last_ff    <= load_last;
      end
   end

   always_comb begin
      stat.op          = op_ff;
      stat.hit         = hit_ff;
      stat.free_found  = free_ff;
      stat.idx_ok      = (op_ff == OP_BUTTON) ? (idx_ff < 8'(BUTTON_COUNT))
                                              : (idx_ff < 8'(AXIS_COUNT));
      stat.out_free    = out_free;
      stat.walk_empty  = (btn_walk_ff == '0) && (axis_walk_ff == '0);
      stat.rel_valid   = rel_valid_ff;
      stat.press_valid = press_valid_ff;
   end

   assign csr_if.ready         = 1'b1;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.slot          = rsp_slot_ff;
   assign rsp_if.control_kind  = rsp_kind_ff;
   assign rsp_if.control_index = rsp_index_ff;
   assign rsp_if.pressed       = rsp_pressed_ff;
   assign rsp_if.last          = rsp_last_ff;

   // a device id is bound to at most one slot
   a_unique_binding: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("device bound to more than one slot");

endmodule
`default_nettype wire

@@ hdl/gect_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gect_ctrl: event sequencer
// Steps each event through capture, slot lookup, decision, state update and
// result emission, or through the walk that releases a removed device.
// ----------------------------------------------------------------------------
module gect_ctrl
   import gect_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_DECIDE,
      S_UPDATE,
      S_REL,
      S_PRESS,
      S_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            unique case (stat.op)
               OP_ADD: begin
                  cmd.alloc = !stat.hit && stat.free_found;
               end
               OP_REMOVE: begin
                  if (stat.hit) begin
                     cmd.remove = 1'b1;
                     cmd.select = 1'b1;
                     state_in   = S_WALK;
                  end
               end
               default: begin
                  if (stat.idx_ok && (stat.hit || stat.free_found)) begin
                     cmd.select = 1'b1;
                     cmd.alloc  = !stat.hit;
                     state_in   = S_UPDATE;
                  end
               end
            endcase
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_REL;
         end
         S_REL: begin
            if (!stat.rel_valid) begin
               state_in = S_PRESS;
            end else if (stat.out_free) begin
               cmd.emit_rel = 1'b1;
               state_in     = S_PRESS;
            end
         end
         S_PRESS: begin
            if (!stat.press_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_press = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_WALK: begin
            if (stat.walk_empty) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_rel || cmd.emit_press || cmd.walk_step) |-> stat.out_free)
      else $error("result loaded while output register busy");

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_LOOK))
      else $error("accepted event not looked up");

   a_alloc_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> (!stat.hit && stat.free_found))
      else $error("slot allocated for known device or with no free slot");

endmodule
`default_nettype wire

@@ hdl/gamepad_event_change_tracker_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_event_change_tracker_core: controller event change tracker
// Usage:
//   req_if carries raw events (device added, device removed, button, axis).
//   Each device id is bound to the lowest free slot; per slot a held bit per
//   button and a direction per axis are kept. rsp_if carries one press or
//   release change per transfer, with last set on the final change of an
//   event. csr_if writes the axis threshold; it is always ready and should
//   only be written while no event is in flight.
// Timing:
//   An event is one transfer on req_if; lookup and decide follow. An add, an
//   unknown removal or a dropped event then ends. A button or axis event that
//   reaches a slot goes on to update, then release, then press on rsp_if.
//   A removal walks the slot's buttons then axes, one per cycle while the
//   output register is free, stopping after the last active control.
//   The sequencer handles one event at a time.
// Reset clears all slots and all control state and sets the threshold to 0x1fff.
// A stalled rsp_if holds the sequencer until the output register drains.
// ----------------------------------------------------------------------------
module gamepad_event_change_tracker_core
   import gect_pkg::*;
#(
   parameter int MAX_SLOTS    = 8,
   parameter int BUTTON_COUNT = 32,
   parameter int AXIS_COUNT   = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gect_req_if.sink   req_if,
   gect_rsp_if.source rsp_if,
   gect_csr_if.sink   csr_if
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   gect_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gect_datapath #(
      .MAX_SLOTS    (MAX_SLOTS),
      .BUTTON_COUNT (BUTTON_COUNT),
      .AXIS_COUNT   (AXIS_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_if.op),
      .req_dev_handle (req_if.dev_handle),
      .req_index      (req_if.index),
      .req_value      (req_if.value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_if         (rsp_if),
      .csr_if         (csr_if)
   );

   assign req_if.ready = req_ready;

endmodule
`default_nettype wire
